/* rtl/core/cls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types and constants for the comment and literal scanner.
// ----------------------------------------------------------------------------
package cls_pkg;

   localparam int SPAN_BITS   = 16;
   localparam int KIND_BITS   = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   localparam logic [7:0] CHR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHR_SLASH     = 8'h2F;
   localparam logic [7:0] CHR_STAR      = 8'h2A;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_STRING  = 2'd0,
      KIND_CHAR    = 2'd1,
      KIND_COMMENT = 2'd2,
      KIND_ESCAPE  = 2'd3
   } span_kind_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_REPORT_LITERALS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REPORT_COMMENTS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REPORT_ESCAPES  = 2'd2;

   typedef struct packed {
      logic report_literals;
      logic report_comments;
      logic report_escapes;
   } cfg_type;

   typedef struct packed {
      logic [SPAN_BITS-1:0] span_start;
      logic [SPAN_BITS-1:0] span_end;
      span_kind_type        span_kind;
   } span_type;

   typedef enum logic [5:0] {
      MODE_NORMAL  = 6'b000001,
      MODE_SLASH   = 6'b000010,
      MODE_STRING  = 6'b000100,
      MODE_CHAR    = 6'b001000,
      MODE_COMMENT = 6'b010000,
      MODE_ESCAPE  = 6'b100000
   } scan_mode_type;

endpackage

/* rtl/core/cls_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_req_if
// Request channel: one source byte with a last-byte mark.
// ----------------------------------------------------------------------------
interface cls_req_if
   import cls_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       is_last;

   modport source (output valid, output text_byte, output is_last, input ready);
   modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

/* rtl/core/cls_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_rsp_if
// Result channel: one closed span.
// ----------------------------------------------------------------------------
interface cls_rsp_if
   import cls_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [SPAN_BITS-1:0] span_start;
   logic [SPAN_BITS-1:0] span_end;
   logic [KIND_BITS-1:0] span_kind;

   modport source (output valid, output span_start, output span_end, output span_kind,
                   input ready);
   modport sink   (input valid, input span_start, input span_end, input span_kind,
                   output ready);
endinterface

/* rtl/core/cls_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_front
// Per-byte scanner state machine; pushes closed, enabled spans to the queue.
// ----------------------------------------------------------------------------
module cls_front
   import cls_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   cls_req_if.sink  req_ch,
   input  cfg_type  cfg,
   input  logic     queue_full,
   output logic     push_valid,
   output span_type push_data
);

   scan_mode_type       mode_ff, mode_in, mode_step;
   logic                esc_ff, esc_in;
   logic                star_ff, star_in;
   logic [POS_BITS-1:0] open_ff, open_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;

   logic                accept;
   logic                closed;
   logic                fire;
   span_kind_type       kind;
   logic [7:0]          c;
   logic                enabled;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign c            = req_ch.text_byte;

   always_comb begin
      mode_step = mode_ff;
      esc_in    = esc_ff;
      star_in   = star_ff;
      open_in   = open_ff;
      closed    = 1'b0;
      kind      = KIND_STRING;

      unique case (mode_ff)
         MODE_STRING, MODE_CHAR: begin
            if (c == ((mode_ff == MODE_STRING) ? CHR_DQUOTE : CHR_SQUOTE) && !esc_ff) begin
               closed = 1'b1;
               kind   = (mode_ff == MODE_STRING) ? KIND_STRING : KIND_CHAR;
            end else begin
               esc_in = (c == CHR_BACKSLASH) ? !esc_ff : 1'b0;
            end
         end
         MODE_COMMENT: begin
            if (star_ff && c == CHR_SLASH) begin
               closed = 1'b1;
               kind   = KIND_COMMENT;
            end else begin
               star_in = (c == CHR_STAR);
            end
         end
         MODE_ESCAPE: begin
            closed = 1'b1;
            kind   = KIND_ESCAPE;
         end
         default: begin
            // slash seen falls into normal handling unless this is the star
            if (mode_ff == MODE_SLASH && c == CHR_STAR) begin
               mode_step = MODE_COMMENT;
               star_in   = 1'b0;
            end else if (c == CHR_DQUOTE) begin
               mode_step = MODE_STRING;
               esc_in    = 1'b0;
               open_in   = pos_ff;
            end else if (c == CHR_SQUOTE) begin
               mode_step = MODE_CHAR;
               esc_in    = 1'b0;
               open_in   = pos_ff;
            end else if (c == CHR_SLASH) begin
               mode_step = MODE_SLASH;
               open_in   = pos_ff;
            end else if (c == CHR_BACKSLASH) begin
               mode_step = MODE_ESCAPE;
               open_in   = pos_ff;
            end else begin
               mode_step = MODE_NORMAL;
            end
         end
      endcase

      fire = closed;
      if (req_ch.is_last && !closed) begin
         priority case (mode_step)
            MODE_STRING:  begin fire = 1'b1; kind = KIND_STRING;  end
            MODE_CHAR:    begin fire = 1'b1; kind = KIND_CHAR;    end
            MODE_COMMENT: begin fire = 1'b1; kind = KIND_COMMENT; end
            MODE_ESCAPE:  begin fire = 1'b1; kind = KIND_ESCAPE;  end
            default:      fire = 1'b0;
         endcase
      end

      mode_in = mode_step;
      if (fire) begin
         mode_in = MODE_NORMAL;
         esc_in  = 1'b0;
         star_in = 1'b0;
      end

      pos_in = pos_ff;
      if (req_ch.is_last) begin
         mode_in = MODE_NORMAL;
         esc_in  = 1'b0;
         star_in = 1'b0;
         pos_in  = '0;
      end else if (pos_ff != {POS_BITS{1'b1}}) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_comb begin
      unique case (kind)
         KIND_COMMENT: enabled = cfg.report_comments;
         KIND_ESCAPE:  enabled = cfg.report_escapes;
         default:      enabled = cfg.report_literals;
      endcase
   end

   assign push_valid           = accept && fire && enabled;
   assign push_data.span_start = SPAN_BITS'(open_in);
   assign push_data.span_end   = SPAN_BITS'(pos_ff);
   assign push_data.span_kind  = kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         esc_ff  <= 1'b0;
         star_ff <= 1'b0;
         open_ff <= '0;
         pos_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         star_ff <= star_in;
         open_ff <= req_ch.is_last ? '0 : open_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

/* rtl/core/cls_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_queue
// Small FIFO of closed spans between the scanner and the output stage.
// ----------------------------------------------------------------------------
module cls_queue
   import cls_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  span_type push_data,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop_ready,
   output span_type pop_data
);

   span_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/core/cls_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_back
// Output register stage driving the result channel.
// ----------------------------------------------------------------------------
module cls_back
   import cls_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  span_type in_data,
   cls_rsp_if.source rsp_ch
);

   logic     valid_ff, valid_in;
   span_type data_ff;

   assign in_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= in_data;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.span_start = data_ff.span_start;
   assign rsp_ch.span_end   = data_ff.span_end;
   assign rsp_ch.span_kind  = data_ff.span_kind;

endmodule

/* rtl/core/comment_and_literal_scanner_unit.sv */
`timescale 1ns / 1ps
// A span passes through the span queue and then the output register before it appears on rsp.
// Throughput: one request per cycle while the span queue is not full; the scanner state machine updates per byte.
// A four-entry span queue and the output register let the two sides stall apart.
// Reset (synchronous, active high) returns scan state to normal, empties the
// queue and output stage, and restores the report enables to literals and comments on.
// ----------------------------------------------------------------------------
// comment_and_literal_scanner_unit
// Streams C text and reports string, character, comment and escape spans.
// ----------------------------------------------------------------------------
module comment_and_literal_scanner_unit
   import cls_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   cls_req_if.sink                  req_ch,
   cls_rsp_if.source                rsp_ch,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data
);

   cfg_type  cfg_ff;
   logic     queue_full;
   logic     push_valid;
   span_type push_data;
   logic     pop_valid, pop_ready;
   span_type pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.report_literals <= 1'b1;
         cfg_ff.report_comments <= 1'b1;
         cfg_ff.report_escapes  <= 1'b0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_REPORT_LITERALS) cfg_ff.report_literals <= csr_write_data[0];
         if (csr_index == CSR_REPORT_COMMENTS) cfg_ff.report_comments <= csr_write_data[0];
         if (csr_index == CSR_REPORT_ESCAPES)  cfg_ff.report_escapes  <= csr_write_data[0];
      end
   end

   cls_front #(.POS_BITS(POS_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   cls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cls_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pop_valid),
      .in_ready (pop_ready),
      .in_data  (pop_data),
      .rsp_ch   (rsp_ch)
   );

endmodule
